### src/cra_pkg.sv
// Shared types and constants for the contiguous run allocator.
// Used by cra_front, cra_back and the top level; no dependencies.
`timescale 1ns / 1ps

package cra_pkg;

  localparam int LEN_W  = 11;  // run_length and result_base width
  localparam int BASE_W = 12;  // base_slot width
  localparam int RUN_W  = 12;  // free-run counter, holds up to run_length + 1
  localparam int STAT_W = 2;

  localparam logic [1:0] SLOT_FREE  = 2'd0;
  localparam logic [1:0] SLOT_USED  = 2'd1;
  localparam logic [1:0] SLOT_GUARD = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    CMD_ALLOC     = 2'd0,
    CMD_FREE      = 2'd1,
    CMD_REJ_ALLOC = 2'd2,
    CMD_REJ_FREE  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [LEN_W-1:0]    len;
    logic [BASE_W-1:0]   base;
  } cmd_t;

endpackage

### src/cra_front.sv
// Front end: accepts request beats, classifies them and queues them for the back end.
// Depends on cra_pkg.
`timescale 1ns / 1ps

module cra_front #(
  parameter int MAP_SLOTS = 2048
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [23:0]               s_tdata,
  input  logic                      clearing,
  output logic                      cmd_valid,
  output cra_pkg::cmd_t             cmd,
  input  logic                      cmd_pop
);
  import cra_pkg::*;

  localparam int DEPTH = 2;

  cmd_t        entries [DEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;
  cmd_t        cmd_in;

  logic              in_action;
  logic [LEN_W-1:0]  in_len;
  logic [BASE_W-1:0] in_base;

  assign in_action = s_tdata[0];
  assign in_len    = s_tdata[LEN_W:1];
  assign in_base   = s_tdata[LEN_W+BASE_W:LEN_W+1];

  // Reject zero-length allocates and out-of-map frees up front.
  always_comb begin
    cmd_in.len  = in_len;
    cmd_in.base = in_base;
    if (in_action == ACT_ALLOC) begin
      cmd_in.kind = (in_len == '0) ? CMD_REJ_ALLOC : CMD_ALLOC;
    end else begin
      cmd_in.kind = (32'(in_base) >= MAP_SLOTS) ? CMD_REJ_FREE : CMD_FREE;
    end
  end

  assign s_tready  = (count != 2'(DEPTH)) && !clearing;
  assign push      = s_tvalid && s_tready;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= cmd_in;
  end

endmodule

### src/cra_back.sv
// Back end: slot map memory, allocate scan, mark and free walks, result register.
// Depends on cra_pkg; fed by cra_front.
`timescale 1ns / 1ps

module cra_back #(
  parameter int SLOTS_PER_TABLE = 512,
  parameter int MAP_SLOTS       = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [cra_pkg::LEN_W-1:0]     cfg_wdata,
  input  logic                          cmd_valid,
  input  cra_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  output logic                          clearing,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata
);
  import cra_pkg::*;

  localparam int IDX_W = $clog2(MAP_SLOTS + 1);
  localparam int CNT_W = (IDX_W > 13) ? IDX_W : 13;
  localparam int MAP_W = $clog2(MAP_SLOTS);
  localparam logic [CNT_W-1:0] MAP_C  = CNT_W'(MAP_SLOTS);
  localparam logic [CNT_W-1:0] LAST_C = CNT_W'(MAP_SLOTS - 1);
  localparam logic [CNT_W-1:0] SPT_C  = CNT_W'(SLOTS_PER_TABLE);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_MARK  = 7'b0001000,
    S_FREE  = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_HOLD  = 7'b1000000
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   addr, addr_next;
  logic [CNT_W-1:0]   bnd, bnd_next;
  logic [CNT_W-1:0]   hit, hit_next;
  logic               pass, pass_next;
  logic [RUN_W-1:0]   run, run_next;
  logic [LEN_W-1:0]   len, len_next;
  logic [STAT_W-1:0]  res_status, res_status_next;
  logic [LEN_W-1:0]   res_base, res_base_next;
  logic [LEN_W-1:0]   search_start;
  logic               rd_vld, rd_vld_next;
  logic [CNT_W-1:0]   rd_idx, rd_idx_next;
  logic [1:0]         rd;
  logic               out_valid;
  logic [STAT_W-1:0]  out_status;
  logic [LEN_W-1:0]   out_base;
  logic               load;

  logic [1:0]         mem [MAP_SLOTS];
  logic               we;
  logic [MAP_W-1:0]   wa;
  logic [1:0]         wd;
  logic               issue;

  logic [CNT_W-1:0]   start;
  logic [RUN_W-1:0]   need;
  logic [RUN_W-1:0]   run_inc;
  logic               found;
  logic               guard_hit;
  logic               scan_ok;
  logic [CNT_W-1:0]   first;

  assign start     = CNT_W'(search_start);
  assign need      = RUN_W'(len) + 1'b1;
  assign run_inc   = run + 1'b1;
  assign found     = rd_vld && (rd == SLOT_FREE) && (run_inc >= need);
  assign guard_hit = rd_vld && (rd == SLOT_GUARD);
  assign first     = rd_idx - CNT_W'(len);
  // Second pass ends at the first table boundary past search_start.
  assign scan_ok   = (addr < MAP_C) && !(pass && (addr == bnd) && (start < bnd));

  always_comb begin
    state_next      = state;
    addr_next       = addr;
    bnd_next        = bnd;
    hit_next        = hit;
    pass_next       = pass;
    run_next        = run;
    len_next        = len;
    res_status_next = res_status;
    res_base_next   = res_base;
    cmd_pop         = 1'b0;
    we              = 1'b0;
    wa              = addr[MAP_W-1:0];
    wd              = SLOT_FREE;
    issue           = 1'b0;
    load            = 1'b0;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        if (addr == LAST_C) begin
          state_next = S_IDLE;
        end else begin
          addr_next = addr + 1'b1;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_ALLOC: begin
              len_next   = cmd.len;
              addr_next  = start + 1'b1;
              pass_next  = 1'b0;
              run_next   = '0;
              state_next = S_SCAN;
            end
            CMD_FREE: begin
              addr_next  = CNT_W'(cmd.base);
              state_next = S_FREE;
            end
            CMD_REJ_ALLOC: begin
              res_status_next = STAT_NOFIT;
              res_base_next   = '0;
              state_next      = S_DONE;
            end
            default: begin
              res_status_next = STAT_RANGE;
              res_base_next   = '0;
              state_next      = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_vld) run_next = (rd == SLOT_FREE) ? run_inc : '0;
        if (found) begin
          hit_next        = rd_idx;
          addr_next       = first;
          res_status_next = STAT_OK;
          res_base_next   = first[LEN_W-1:0];
          state_next      = S_MARK;
        end else if (scan_ok) begin
          issue     = 1'b1;
          addr_next = addr + 1'b1;
          if (pass && (addr == bnd)) bnd_next = bnd + SPT_C;
        end else if (!pass) begin
          // wrap to slot 0 with the run count cleared
          pass_next = 1'b1;
          addr_next = '0;
          run_next  = '0;
          bnd_next  = SPT_C;
        end else begin
          res_status_next = STAT_NOFIT;
          res_base_next   = '0;
          state_next      = S_DONE;
        end
      end
      S_MARK: begin
        we = 1'b1;
        if (addr == hit) begin
          wd         = SLOT_GUARD;
          state_next = S_DONE;
        end else begin
          wd        = SLOT_USED;
          addr_next = addr + 1'b1;
        end
      end
      S_FREE: begin
        // clear each slot as its read returns; stop on the guard
        if (rd_vld) begin
          we = 1'b1;
          wa = rd_idx[MAP_W-1:0];
        end
        if (guard_hit || !(addr < MAP_C)) begin
          res_status_next = STAT_OK;
          res_base_next   = '0;
          state_next      = S_DONE;
        end else begin
          issue     = 1'b1;
          addr_next = addr + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid || m_tready) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid || m_tready) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign rd_vld_next = issue;
  assign rd_idx_next = addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      addr         <= '0;
      rd_vld       <= 1'b0;
      out_valid    <= 1'b0;
      search_start <= '0;
    end else begin
      state  <= state_next;
      addr   <= addr_next;
      rd_vld <= rd_vld_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wen) search_start <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    bnd        <= bnd_next;
    hit        <= hit_next;
    pass       <= pass_next;
    run        <= run_next;
    len        <= len_next;
    res_status <= res_status_next;
    res_base   <= res_base_next;
    rd_idx     <= rd_idx_next;
    if (load) begin
      out_status <= res_status;
      out_base   <= res_base;
    end
  end

  // Slot map: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd <= mem[addr[MAP_W-1:0]];
  end

  assign clearing = (state == S_CLEAR);
  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_base, out_status};

endmodule

### src/contiguous_run_allocator.sv
// Top level of the first-fit contiguous run allocator; the search begins after search_start.
// Depends on cra_pkg, cra_front and cra_back.
//
//   channel  dir  signals                       beat contents
//   s_*      in   s_tvalid s_tready s_tdata     allocate or free request
//   m_*      out  m_tvalid m_tready m_tdata     status and allocated base
//   cfg_*    in   cfg_wen cfg_wdata             search_start register write
//
// After reset a clearing pass writes every slot free with s_tready low; cfg writes
// are taken during it. An allocate scans from search_start + 1 to the end of the
// map, then wraps to slot 0 up to the first table boundary past search_start, and
// marks the len + 1 slots of the run, the last as guard; a free walks slots from
// base_slot until it clears a guard or reaches the map's end. The slot map's single
// read port sets the pace. A two-beat request queue and the result register let each
// side stall on its own.
`timescale 1ns / 1ps

module contiguous_run_allocator #(
  parameter int SLOTS_PER_TABLE = 512,
  parameter int TABLE_COUNT     = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [23:0]                s_tdata,   // action, run_length[10:0], base_slot[11:0]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [15:0]                m_tdata,   // status[1:0], result_base[10:0], zero pad
  input  logic                       cfg_wen,
  input  logic [cra_pkg::LEN_W-1:0]  cfg_wdata
);
  import cra_pkg::*;

  localparam int MAP_SLOTS = SLOTS_PER_TABLE * TABLE_COUNT;

  logic  cmd_valid;
  logic  cmd_pop;
  logic  clearing;
  cmd_t  cmd;

  cra_front #(
    .MAP_SLOTS (MAP_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  cra_back #(
    .SLOTS_PER_TABLE (SLOTS_PER_TABLE),
    .MAP_SLOTS       (MAP_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .clearing  (clearing),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

### verif/cra_checker.sv
`timescale 1ns / 1ps
// Scoreboard for contiguous_run_allocator: keeps its own copy of the slot map and
// of search_start, predicts one result per request beat and checks the m_* beats.
// Depends on cra_pkg.

module cra_checker #(
  parameter int SLOTS_PER_TABLE = 512,
  parameter int TABLE_COUNT     = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [23:0]               s_tdata,   // action, run_length[10:0], base_slot[11:0]
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [15:0]               m_tdata,   // status[1:0], result_base[10:0], zero pad
  input  logic                      cfg_wen,
  input  logic [cra_pkg::LEN_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending,
  output int                        done_seen,
  output int                        nofit_seen,
  output int                        range_seen
);
  import cra_pkg::*;

  localparam int MAP_SLOTS = SLOTS_PER_TABLE * TABLE_COUNT;

  // Member order matches m_tdata[12:0]: base above status.
  typedef struct packed {
    logic [LEN_W-1:0]  base;
    logic [STAT_W-1:0] status;
  } grant_t;

  logic [1:0]       slot_map [MAP_SLOTS];
  logic [LEN_W-1:0] search_from;
  grant_t           grants_due [$];

  // Find `need` free slots in a row inside [lo, hi); report the last one.
  function automatic bit find_free_run(input int lo, input int hi, input int need,
                                       output int hit);
    int run;
    int i;
    run = 0;
    hit = 0;
    for (i = lo; i < hi && i < MAP_SLOTS; i++) begin
      if (slot_map[i] == SLOT_FREE) begin
        run++;
        if (run >= need) begin
          hit = i;
          return 1'b1;
        end
      end else begin
        run = 0;
      end
    end
    return 1'b0;
  endfunction

  // Apply one request to the map and return the result it must produce.
  function automatic grant_t serve_request(input logic act, input logic [LEN_W-1:0] len,
                                           input logic [BASE_W-1:0] base);
    grant_t     g;
    int         hit;
    int         wrap_end;
    int         first;
    int         i;
    bit         found;
    logic [1:0] was;
    g.status = STAT_OK;
    g.base   = '0;
    found    = 1'b0;
    hit      = 0;
    if (act == ACT_ALLOC) begin
      if (len != '0) begin
        wrap_end = (int'(search_from) / SLOTS_PER_TABLE + 1) * SLOTS_PER_TABLE;
        if (wrap_end > MAP_SLOTS) wrap_end = MAP_SLOTS;
        found = find_free_run(int'(search_from) + 1, MAP_SLOTS, int'(len) + 1, hit);
        // second pass starts over at slot 0 with an empty run count
        if (!found) found = find_free_run(0, wrap_end, int'(len) + 1, hit);
      end
      if (found) begin
        first = hit - int'(len);
        for (i = first; i < hit; i++) slot_map[i] = SLOT_USED;
        slot_map[hit] = SLOT_GUARD;
        g.base = first[LEN_W-1:0];
      end else begin
        g.status = STAT_NOFIT;
      end
    end else if (int'(base) >= MAP_SLOTS) begin
      g.status = STAT_RANGE;
    end else begin
      i = int'(base);
      while (i < MAP_SLOTS) begin
        was = slot_map[i];
        slot_map[i] = SLOT_FREE;
        if (was == SLOT_GUARD) break;
        i++;
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t due;
    grant_t seen;
    if (rst) begin
      foreach (slot_map[i]) slot_map[i] = SLOT_FREE;
      search_from = '0;
      grants_due.delete();
      fail_count = 0;
      done_seen  = 0;
      nofit_seen = 0;
      range_seen = 0;
    end else begin
      // drain the result side first: a result always belongs to an older request
      if (m_tvalid && m_tready) begin
        seen = m_tdata[LEN_W+STAT_W-1:0];
        if (grants_due.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing due, expected none, got status %0d base %0d",
                   $time, seen.status, seen.base);
        end else begin
          due = grants_due.pop_front();
          if (seen.status !== due.status) begin
            fail_count++;
            $display("%0t: status expected %0d, got %0d", $time, due.status, seen.status);
          end
          if (seen.base !== due.base) begin
            fail_count++;
            $display("%0t: result_base expected %0d, got %0d", $time, due.base, seen.base);
          end
          case (due.status)
            STAT_OK:    done_seen++;
            STAT_NOFIT: nofit_seen++;
            default:    range_seen++;
          endcase
        end
      end
      if (s_tvalid && s_tready)
        grants_due.push_back(serve_request(s_tdata[0], s_tdata[LEN_W:1],
                                           s_tdata[LEN_W+BASE_W:LEN_W+1]));
      if (cfg_wen) search_from = cfg_wdata;
    end
    pending = grants_due.size();
  end

endmodule

### verif/tb_contiguous_run_allocator.sv
`timescale 1ns / 1ps
// Testbench top for contiguous_run_allocator: drives requests, results stall and
// search_start writes; cra_checker does the prediction. Depends on cra_pkg,
// cra_checker and the allocator RTL.

module tb_contiguous_run_allocator;
  import cra_pkg::*;

  localparam int SLOTS_PER_TABLE = 512;
  localparam int TABLE_COUNT     = 4;
  localparam int MAP_SLOTS       = SLOTS_PER_TABLE * TABLE_COUNT;
  localparam int LONG_HOLD       = 600;
  localparam int PHASE_ITEMS     = 45;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [23:0]      s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [15:0]      m_tdata;
  logic             cfg_wen;
  logic [LEN_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int done_seen;
  int nofit_seen;
  int range_seen;
  int burst_left;
  int n_alloc;
  int n_free;
  int n_settings;
  bit hold_wanted;
  bit hold_done;

  logic [LEN_W-1:0] live_bases [$];

  contiguous_run_allocator #(
    .SLOTS_PER_TABLE(SLOTS_PER_TABLE),
    .TABLE_COUNT    (TABLE_COUNT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  cra_checker #(
    .SLOTS_PER_TABLE(SLOTS_PER_TABLE),
    .TABLE_COUNT    (TABLE_COUNT)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending),
    .done_seen (done_seen),
    .nofit_seen(nofit_seen),
    .range_seen(range_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("timeout: requests or results stopped moving");
    $display("FAILED: results differ");
    $finish;
  end

  // Remember handed-out bases so most frees land on real runs.
  always @(posedge clk)
    if (!rst && m_tvalid && m_tready && m_tdata[STAT_W-1:0] == STAT_OK &&
        m_tdata[LEN_W+STAT_W-1:STAT_W] != '0)
      live_bases.push_back(m_tdata[LEN_W+STAT_W-1:STAT_W]);

  // Result side: stretches of steady, sparse, busy or stalled tready, plus one long hold.
  initial begin
    int stretch;
    int mode;
    stretch   = 0;
    mode      = 0;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_wanted && !hold_done) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
      end
      if (stretch == 0) begin
        mode    = $urandom_range(0, 3);
        stretch = $urandom_range(4, 60);
      end
      stretch--;
      case (mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ($urandom_range(0, 3) != 0);
        2:       m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= 1'b0;
      endcase
    end
  end

  // Offer one request beat; between bursts leave a random gap.
  task automatic send_request(input logic act, input logic [LEN_W-1:0] len,
                              input logic [BASE_W-1:0] base);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {base, len, act};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    burst_left--;
    if (act == ACT_ALLOC) n_alloc++;
    else n_free++;
  endtask

  task automatic send_alloc(input logic [LEN_W-1:0] len);
    send_request(ACT_ALLOC, len, BASE_W'($urandom));
  endtask

  task automatic send_free(input logic [BASE_W-1:0] base);
    send_request(ACT_FREE, LEN_W'($urandom), base);
  endtask

  // Hold the request side until every result has come back.
  task automatic drain;
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic set_search_start(input logic [LEN_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    n_settings++;
  endtask

  // Mostly short runs and frees of live bases; some long runs and stray frees.
  task automatic send_random;
    int               pick;
    int               idx;
    logic [LEN_W-1:0] base;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      send_alloc('0);
    end else if (pick < 45) begin
      send_alloc(LEN_W'($urandom_range(1, 16)));
    end else if (pick < 52) begin
      send_alloc(LEN_W'($urandom_range(17, 300)));
    end else if (pick < 55) begin
      send_alloc(LEN_W'($urandom_range(1, MAP_SLOTS - 1)));
    end else if (pick < 92 && live_bases.size() != 0) begin
      idx  = $urandom_range(0, live_bases.size() - 1);
      base = live_bases[idx];
      live_bases.delete(idx);
      send_free(BASE_W'(base));
    end else if (pick < 96) begin
      send_free(BASE_W'($urandom_range(0, MAP_SLOTS - 1)));
    end else begin
      send_free(BASE_W'($urandom_range(0, 4095)));
    end
  endtask

  initial begin
    logic [LEN_W-1:0] starts [6];
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    cfg_wen     = 1'b0;
    cfg_wdata   = '0;
    burst_left  = 0;
    n_alloc     = 0;
    n_free      = 0;
    n_settings  = 0;
    hold_wanted = 1'b0;
    starts[0]   = LEN_W'($urandom_range(1, MAP_SLOTS - 2));
    starts[1]   = '0;
    starts[2]   = LEN_W'(MAP_SLOTS - 1);
    starts[3]   = LEN_W'(SLOTS_PER_TABLE - 1);
    starts[4]   = LEN_W'(SLOTS_PER_TABLE);
    starts[5]   = LEN_W'(3 * SLOTS_PER_TABLE);
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // search from slot 1: zero length, small and full-map runs, range and guard-less frees
    set_search_start('0);
    send_alloc('0);
    send_alloc(1);
    send_alloc(5);
    send_alloc(LEN_W'(MAP_SLOTS - 1));
    send_free(1);
    send_free(BASE_W'(MAP_SLOTS));
    send_free(12'hFFF);
    send_free(2000);
    send_free(3);
    send_alloc(1);
    drain();

    // start at the last slot: first pass is empty, whole map from slot 0
    set_search_start(LEN_W'(MAP_SLOTS - 1));
    send_free(0);
    send_alloc(LEN_W'(MAP_SLOTS - 1));
    send_alloc(1);
    send_free(BASE_W'(MAP_SLOTS - 1));
    send_free(0);
    send_alloc(1024);
    send_free(0);
    drain();

    // mid-map start: later runs must wrap into the start's table
    set_search_start(1023);
    send_alloc(600);
    send_alloc(600);
    send_alloc(600);
    send_free(1024);
    send_alloc(1);
    send_free(0);
    drain();

    foreach (starts[p]) begin
      set_search_start(starts[p]);
      hold_wanted = 1'b1;
      repeat (PHASE_ITEMS) send_random();
      drain();
    end

    repeat (32) @(negedge clk);
    $display("Sent %0d requests (%0d allocate, %0d free) under %0d search_start values;",
             n_alloc + n_free, n_alloc, n_free, n_settings);
    $display("results: %0d done, %0d no room, %0d free index out of range.",
             done_seen, nofit_seen, range_seen);
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

### files.f
src/cra_pkg.sv
src/cra_front.sv
src/cra_back.sv
src/contiguous_run_allocator.sv
verif/cra_checker.sv
verif/tb_contiguous_run_allocator.sv
